>>> rtl/mctt_pkg.sv
`default_nettype none

package mctt_pkg;

  // Field widths
  localparam int unsigned OP_W       = 3;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned STEP_W     = 10;
  localparam int unsigned LINK_W     = 16;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned MOD_W      = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Millisecond clock residue tracking
  localparam int unsigned MS_PER_SEC = 1000;
  // Residue to add when the 32-bit millisecond clock wraps
  localparam int unsigned MS_WRAP_ADJ =
    MS_PER_SEC - int'((longint'(1) << CNT_W) % longint'(MS_PER_SEC));

  // Register reset values
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);
  localparam logic [LINK_W-1:0] LINK_RESET = LINK_W'(25);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_START      = 3'd1,
    OP_STOP       = 3'd2,
    OP_QUERY      = 3'd3,
    OP_LINK_START = 3'd4,
    OP_LINK_STOP  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    TS_STOPPED = 2'd0,
    TS_RUNNING = 2'd1,
    TS_EXPIRED = 2'd2
  } tmr_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_RPT,
    S_CAP
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic walk_rd;
    logic walk_upd;
    logic rpt_rd;
    logic capture;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_tick;
  } dp_status_t;

  // Result payload
  typedef struct packed {
    logic              accepted;
    logic              is_running;
    logic              is_expired;
    logic [CNT_W-1:0]  remaining;
    logic [MASK_W-1:0] second_expiry_mask;
    logic              link_timed_out;
    logic              link_active;
    logic [CNT_W-1:0]  ms_time;
    logic [CNT_W-1:0]  sec_time;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/mctt_if.sv
`default_nettype none

// Request channel
interface mctt_req_if;
  logic                          valid;
  logic                          ready;
  logic [mctt_pkg::OP_W-1:0]     operation;
  logic [mctt_pkg::IDX_W-1:0]    timer_index;
  logic                          base_seconds;
  logic [mctt_pkg::CNT_W-1:0]    tick_count;

  modport source (
    output valid, operation, timer_index, base_seconds, tick_count,
    input  ready
  );
  modport sink (
    input  valid, operation, timer_index, base_seconds, tick_count,
    output ready
  );
endinterface

// Result channel
interface mctt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic                          is_running;
  logic                          is_expired;
  logic [mctt_pkg::CNT_W-1:0]    remaining;
  logic [mctt_pkg::MASK_W-1:0]   second_expiry_mask;
  logic                          link_timed_out;
  logic                          link_active;
  logic [mctt_pkg::CNT_W-1:0]    ms_time;
  logic [mctt_pkg::CNT_W-1:0]    sec_time;

  modport source (
    output valid, accepted, is_running, is_expired, remaining,
           second_expiry_mask, link_timed_out, link_active, ms_time, sec_time,
    input  ready
  );
  modport sink (
    input  valid, accepted, is_running, is_expired, remaining,
           second_expiry_mask, link_timed_out, link_active, ms_time, sec_time,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/mctt_ram.sv
`default_nettype none

// Simple dual-port RAM, registered read
module mctt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/mctt_dp.sv
`default_nettype none

module mctt_dp #(
  parameter int unsigned NUM_TIMERS = 8,
  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request payload
  input  wire logic [mctt_pkg::OP_W-1:0]           operation_i,
  input  wire logic [mctt_pkg::IDX_W-1:0]          timer_index_i,
  input  wire logic                                base_seconds_i,
  input  wire logic [mctt_pkg::CNT_W-1:0]          tick_count_i,
  // configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [mctt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [mctt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // control
  input  wire mctt_pkg::cmd_t                      cmd_i,
  input  wire logic [IW-1:0]                       walk_rd_addr_i,
  input  wire logic [IW-1:0]                       walk_upd_addr_i,
  output mctt_pkg::dp_status_t                     status_o,
  output mctt_pkg::rsp_t                           rsp_o
);

  // Latched request
  logic [mctt_pkg::OP_W-1:0]   op_q;
  logic [mctt_pkg::IDX_W-1:0]  idx_q;
  logic                        base_q;
  logic [mctt_pkg::CNT_W-1:0]  ticks_q;

  // Configuration
  logic [mctt_pkg::STEP_W-1:0] step_q;
  logic [mctt_pkg::LINK_W-1:0] timeout_q;

  // Clocks, link timer and per-request flags
  logic [mctt_pkg::CNT_W-1:0]  ms_q, ms_d;
  logic [mctt_pkg::MOD_W-1:0]  ms_mod_q, ms_mod_d;
  logic [mctt_pkg::CNT_W-1:0]  sec_q, sec_d;
  logic [mctt_pkg::LINK_W-1:0] link_el_q, link_el_d;
  logic                        link_run_q, link_run_d;
  logic                        second_q, second_d;
  logic [mctt_pkg::MASK_W-1:0] mask_q, mask_d;
  logic                        fired_q, fired_d;
  logic                        acc_q, acc_d;

  // Per-timer status
  mctt_pkg::tmr_state_e        tst_q [NUM_TIMERS];
  mctt_pkg::tmr_state_e        tst_d [NUM_TIMERS];
  logic                        sbase_q [NUM_TIMERS];
  logic                        sbase_d [NUM_TIMERS];

  mctt_pkg::rsp_t              rsp_q;

  // Countdown RAM
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [mctt_pkg::CNT_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [IW-1:0]               ram_raddr;
  logic [mctt_pkg::CNT_W-1:0]  ram_rdata;

  // Addressed timer
  logic                        idx_ok;
  logic [IW-1:0]               idx_sel;
  mctt_pkg::tmr_state_e        cur_st;
  logic                        start_ok;

  // Tick arithmetic
  logic [mctt_pkg::CNT_W:0]    ms_sum;
  logic [11:0]                 res_r1, res_r2, res_r3;
  logic                        second_now;
  logic [mctt_pkg::LINK_W-1:0] link_sum;

  // Walk update
  mctt_pkg::tmr_state_e        upd_st;
  logic                        upd_base;
  logic [mctt_pkg::CNT_W-1:0]  upd_dec;
  logic                        upd_go;

  logic                        rpt_running;

  assign idx_ok   = idx_q < mctt_pkg::IDX_W'(NUM_TIMERS);
  assign idx_sel  = idx_ok ? idx_q[IW-1:0] : '0;
  assign cur_st   = tst_q[idx_sel];
  assign start_ok = (op_q == mctt_pkg::OP_START) && idx_ok
                    && (cur_st != mctt_pkg::TS_RUNNING);

  assign status_o.is_tick = (op_q == mctt_pkg::OP_TICK);

  // Millisecond clock and its residue modulo one second
  assign ms_sum = {1'b0, ms_q} + (mctt_pkg::CNT_W + 1)'(step_q);
  assign res_r1 = 12'(ms_mod_q) + 12'(step_q);
  assign res_r2 = ms_sum[mctt_pkg::CNT_W] ? res_r1 + 12'(mctt_pkg::MS_WRAP_ADJ) : res_r1;

  always_comb begin
    priority if (res_r2 >= 12'(2 * mctt_pkg::MS_PER_SEC)) begin
      res_r3 = res_r2 - 12'(2 * mctt_pkg::MS_PER_SEC);
    end else if (res_r2 >= 12'(mctt_pkg::MS_PER_SEC)) begin
      res_r3 = res_r2 - 12'(mctt_pkg::MS_PER_SEC);
    end else begin
      res_r3 = res_r2;
    end
  end

  assign second_now = (res_r3 == 12'd0);
  assign link_sum   = link_el_q + mctt_pkg::LINK_W'(step_q);

  // Walk: decrement the entry read on the previous cycle
  assign upd_st   = tst_q[walk_upd_addr_i];
  assign upd_base = sbase_q[walk_upd_addr_i];
  assign upd_dec  = ram_rdata - mctt_pkg::CNT_W'(1);
  assign upd_go   = cmd_i.walk_upd && (upd_st == mctt_pkg::TS_RUNNING)
                    && (!upd_base || second_q);

  // RAM port steering
  assign ram_we    = (cmd_i.exec && start_ok) || upd_go;
  assign ram_waddr = upd_go ? walk_upd_addr_i : idx_sel;
  assign ram_wdata = upd_go ? upd_dec : ticks_q;
  assign ram_re    = cmd_i.walk_rd || cmd_i.rpt_rd;
  assign ram_raddr = cmd_i.walk_rd ? walk_rd_addr_i : idx_sel;

  mctt_ram #(
    .WIDTH (mctt_pkg::CNT_W),
    .DEPTH (NUM_TIMERS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state of the timer bank
  always_comb begin
    ms_d       = ms_q;
    ms_mod_d   = ms_mod_q;
    sec_d      = sec_q;
    link_el_d  = link_el_q;
    link_run_d = link_run_q;
    second_d   = second_q;
    mask_d     = mask_q;
    fired_d    = fired_q;
    acc_d      = acc_q;
    tst_d      = tst_q;
    sbase_d    = sbase_q;

    if (cmd_i.load) begin
      second_d = 1'b0;
      mask_d   = '0;
      fired_d  = 1'b0;
      acc_d    = 1'b0;
    end

    if (cmd_i.exec) begin
      unique case (op_q)
        mctt_pkg::OP_TICK: begin
          acc_d    = 1'b1;
          ms_d     = ms_sum[mctt_pkg::CNT_W-1:0];
          ms_mod_d = res_r3[mctt_pkg::MOD_W-1:0];
          second_d = second_now;
          if (second_now) begin
            sec_d = sec_q + mctt_pkg::CNT_W'(1);
          end
          if (link_run_q) begin
            link_el_d = link_sum;
            if (link_sum >= timeout_q) begin
              fired_d    = 1'b1;
              link_run_d = 1'b0;
            end
          end
        end
        mctt_pkg::OP_START: begin
          if (start_ok) begin
            tst_d[idx_sel]   = mctt_pkg::TS_RUNNING;
            sbase_d[idx_sel] = base_q;
            acc_d            = 1'b1;
          end
        end
        mctt_pkg::OP_STOP: begin
          if (idx_ok) begin
            tst_d[idx_sel] = mctt_pkg::TS_STOPPED;
            acc_d          = 1'b1;
          end
        end
        mctt_pkg::OP_QUERY: begin
          acc_d = idx_ok && (cur_st == mctt_pkg::TS_RUNNING);
        end
        mctt_pkg::OP_LINK_START: begin
          acc_d = 1'b1;
          if (!link_run_q) begin
            link_el_d  = '0;
            link_run_d = 1'b1;
          end
        end
        mctt_pkg::OP_LINK_STOP: begin
          acc_d      = 1'b1;
          link_run_d = 1'b0;
        end
        default: begin
          acc_d = 1'b0;
        end
      endcase
    end

    // Expiry on the walk; only the first eight timers own a mask bit
    if (upd_go && (upd_dec == '0)) begin
      tst_d[walk_upd_addr_i] = mctt_pkg::TS_EXPIRED;
      if (upd_base) begin
        mask_d = mask_q | (mctt_pkg::MASK_W'(1) << mctt_pkg::MASK_W'(walk_upd_addr_i));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= mctt_pkg::STEP_RESET;
      timeout_q  <= mctt_pkg::LINK_RESET;
      ms_q       <= '0;
      ms_mod_q   <= '0;
      sec_q      <= '0;
      link_el_q  <= '0;
      link_run_q <= 1'b0;
      second_q   <= 1'b0;
      mask_q     <= '0;
      fired_q    <= 1'b0;
      acc_q      <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        tst_q[i]   <= mctt_pkg::TS_STOPPED;
        sbase_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == mctt_pkg::CFG_TICK_STEP) begin
          step_q <= cfg_data_i[mctt_pkg::STEP_W-1:0];
        end else if (cfg_idx_i == mctt_pkg::CFG_LINK_TIMEOUT) begin
          timeout_q <= cfg_data_i[mctt_pkg::LINK_W-1:0];
        end
      end
      ms_q       <= ms_d;
      ms_mod_q   <= ms_mod_d;
      sec_q      <= sec_d;
      link_el_q  <= link_el_d;
      link_run_q <= link_run_d;
      second_q   <= second_d;
      mask_q     <= mask_d;
      fired_q    <= fired_d;
      acc_q      <= acc_d;
      tst_q      <= tst_d;
      sbase_q    <= sbase_d;
    end
  end

  // Request payload capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      idx_q   <= timer_index_i;
      base_q  <= base_seconds_i;
      ticks_q <= tick_count_i;
    end
  end

  // Result register
  assign rpt_running = idx_ok && (cur_st == mctt_pkg::TS_RUNNING);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rsp_q.accepted           <= acc_q;
      rsp_q.is_running         <= rpt_running;
      rsp_q.is_expired         <= idx_ok && (cur_st == mctt_pkg::TS_EXPIRED);
      rsp_q.remaining          <= rpt_running ? ram_rdata : '0;
      rsp_q.second_expiry_mask <= mask_q;
      rsp_q.link_timed_out     <= fired_q;
      rsp_q.link_active        <= link_run_q;
      rsp_q.ms_time            <= ms_q;
      rsp_q.sec_time           <= sec_q;
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

>>> rtl/mctt_ctrl.sv
`default_nettype none

module mctt_ctrl #(
  parameter int unsigned NUM_TIMERS = 8,
  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  input  wire mctt_pkg::dp_status_t dp_status_i,
  output mctt_pkg::cmd_t            cmd_o,
  output logic [IW-1:0]             walk_rd_addr_o,
  output logic [IW-1:0]             walk_upd_addr_o
);

  mctt_pkg::ctrl_state_e state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         cnt_m1;
  logic                  walk_last;
  logic                  out_valid_q, out_valid_d;

  assign walk_last       = (cnt_q == CW'(NUM_TIMERS));
  assign cnt_m1          = cnt_q - CW'(1);
  assign walk_rd_addr_o  = cnt_q[IW-1:0];
  assign walk_upd_addr_o = cnt_m1[IW-1:0];
  assign out_valid_o     = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      mctt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mctt_pkg::S_EXEC;
        end
      end
      mctt_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        cnt_d      = '0;
        state_d    = dp_status_i.is_tick ? mctt_pkg::S_WALK : mctt_pkg::S_RPT;
      end
      // read entry cnt, update entry cnt-1
      mctt_pkg::S_WALK: begin
        cmd_o.walk_rd  = !walk_last;
        cmd_o.walk_upd = (cnt_q != '0);
        cnt_d          = cnt_q + CW'(1);
        if (walk_last) begin
          state_d = mctt_pkg::S_RPT;
        end
      end
      mctt_pkg::S_RPT: begin
        cmd_o.rpt_rd = 1'b1;
        state_d      = mctt_pkg::S_CAP;
      end
      mctt_pkg::S_CAP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = mctt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mctt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mctt_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mctt_pkg::S_WALK) |-> (cnt_q <= CW'(NUM_TIMERS)))
    else $error("walk counter past last timer");

  a_cap_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

  a_load_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == mctt_pkg::S_EXEC))
    else $error("accepted request not executed");

  a_upd_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.walk_upd |-> $past(cmd_o.walk_rd))
    else $error("walk update without prior read");
`endif

endmodule

`default_nettype wire

>>> rtl/multi_channel_tick_timer_bank.sv
`default_nettype none

// Bank of NUM_TIMERS countdown timers (millisecond or second base) with a
// millisecond clock, a seconds clock and a link timeout timer. Each request
// (tick, start, stop, query, link start, link stop) yields one result with
// the addressed timer's status and the clocks after the request. One
// request is in flight at a time. After acceptance a request passes the
// states S_EXEC, S_RPT and S_CAP; a tick also passes S_WALK between S_EXEC
// and S_RPT, because the countdown values live in a RAM with one read and
// one write port and the tick walks it one entry per cycle. S_CAP waits
// while the previous result is still held unconsumed. A new request is
// taken once the previous result is in the output register, even if that
// result has not yet been consumed. Configuration: index 0 sets the tick
// step in ms (reset 1), index 1 the link timeout in ms (reset 25); write
// only while idle. No clearing pass after reset.
module multi_channel_tick_timer_bank #(
  parameter int unsigned NUM_TIMERS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  mctt_req_if.sink                               req_i,
  mctt_rsp_if.source                             rsp_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [mctt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mctt_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  mctt_pkg::cmd_t       cmd;
  mctt_pkg::dp_status_t dp_status;
  mctt_pkg::rsp_t       rsp;
  logic [IW-1:0]        walk_rd_addr;
  logic [IW-1:0]        walk_upd_addr;
  logic                 in_ready;
  logic                 out_valid;

  mctt_ctrl #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (req_i.valid),
    .in_ready_o      (in_ready),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (out_valid),
    .dp_status_i     (dp_status),
    .cmd_o           (cmd),
    .walk_rd_addr_o  (walk_rd_addr),
    .walk_upd_addr_o (walk_upd_addr)
  );

  mctt_dp #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .operation_i     (req_i.operation),
    .timer_index_i   (req_i.timer_index),
    .base_seconds_i  (req_i.base_seconds),
    .tick_count_i    (req_i.tick_count),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .walk_rd_addr_i  (walk_rd_addr),
    .walk_upd_addr_i (walk_upd_addr),
    .status_o        (dp_status),
    .rsp_o           (rsp)
  );

  // Channel hookup
  assign req_i.ready              = in_ready;
  assign rsp_o.valid              = out_valid;
  assign rsp_o.accepted           = rsp.accepted;
  assign rsp_o.is_running         = rsp.is_running;
  assign rsp_o.is_expired         = rsp.is_expired;
  assign rsp_o.remaining          = rsp.remaining;
  assign rsp_o.second_expiry_mask = rsp.second_expiry_mask;
  assign rsp_o.link_timed_out     = rsp.link_timed_out;
  assign rsp_o.link_active        = rsp.link_active;
  assign rsp_o.ms_time            = rsp.ms_time;
  assign rsp_o.sec_time           = rsp.sec_time;

endmodule

`default_nettype wire
